/* rtl/barometer_first_order_compensation_top_defines.svh */
// assertion macros for the barometer compensation block
// used by barometer_first_order_compensation_top, no other dependencies
`ifndef BAROMETER_FIRST_ORDER_COMPENSATION_TOP_DEFINES_SVH
`define BAROMETER_FIRST_ORDER_COMPENSATION_TOP_DEFINES_SVH

// same-cycle implication on clk_i, off while in reset
`define BFOC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication on clk_i, off while in reset
`define BFOC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/bfoc_pkg.sv */
// constants and types for the barometer first-order compensation block
// no dependencies
`timescale 1ns / 1ps

package bfoc_pkg;

  localparam int unsigned RawW     = 24;
  localparam int unsigned CoefW    = 16;
  localparam int unsigned DtW      = 25;
  localparam int unsigned TempW    = 19;
  localparam int unsigned PresW    = 32;
  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 56;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned NumCoef  = 6;
  localparam int unsigned NumStage = 6;

  localparam logic signed [TempW-1:0] TempBase = 19'sd2000;
  localparam logic signed [TempW-1:0] TempMin  = -19'sd129068;
  localparam logic signed [TempW-1:0] TempMax  = 19'sd133070;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_C1_SENS    = 3'd0,
    CFG_C2_OFF     = 3'd1,
    CFG_C3_TCS     = 3'd2,
    CFG_C4_TCO     = 3'd3,
    CFG_C5_TREF    = 3'd4,
    CFG_C6_TEMPSENS = 3'd5
  } cfg_idx_e;

endpackage

/* rtl/barometer_first_order_compensation_top.sv */
// barometer first-order compensation, six-stage pipeline
// depends on bfoc_pkg and barometer_first_order_compensation_top_defines.svh
//
//  channel  | dir | handshake                       | payload
//  ---------+-----+---------------------------------+-------------------------------------
//  s_axis   | in  | s_axis_tvalid_i/s_axis_tready_o | tdata: raw_pressure, raw_temperature
//  m_axis   | out | m_axis_tvalid_o/m_axis_tready_i | tdata: pressure, temperature
//           |     |                                 | tuser: readings_valid
//  cfg      | in  | cfg_we_i (no back-pressure)     | cfg_idx_i, cfg_data_i
//
// one transaction per cycle while m_axis_tready_i is high
// stage order follows the multiplier chain: dT products, then the split D1*SENS
// product, then the partial-product sum and the final offset subtract
// each stage moves when it is empty or the next one moves, so bubbles collapse
// under output back-pressure; s_axis_tready_o drops only with all stages full
// reset clears the valid bits and the calibration words; data registers keep junk
`timescale 1ns / 1ps

`include "barometer_first_order_compensation_top_defines.svh"

module barometer_first_order_compensation_top
  import bfoc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // input stream
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [InDataW-1:0]  s_axis_tdata_i,   // [23:0] raw_pressure, [47:24] raw_temperature
  // result stream
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [OutDataW-1:0] m_axis_tdata_o,   // [31:0] pressure_hundredths,
                                                // [50:32] temperature_hundredths, rest 0
  output logic                m_axis_tuser_o,   // [0] readings_valid
  // calibration word writes
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CoefW-1:0]    cfg_data_i
);

  // calibration words C1..C6
  logic [CoefW-1:0] coef_q [NumCoef];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumCoef; i++) begin
        coef_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_C1_SENS:     coef_q[CFG_C1_SENS]     <= cfg_data_i;
        CFG_C2_OFF:      coef_q[CFG_C2_OFF]      <= cfg_data_i;
        CFG_C3_TCS:      coef_q[CFG_C3_TCS]      <= cfg_data_i;
        CFG_C4_TCO:      coef_q[CFG_C4_TCO]      <= cfg_data_i;
        CFG_C5_TREF:     coef_q[CFG_C5_TREF]     <= cfg_data_i;
        CFG_C6_TEMPSENS: coef_q[CFG_C6_TEMPSENS] <= cfg_data_i;
        default: ;  // unused indexes are dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // stage control: valid bits and per-stage advance
  // ---------------------------------------------------------------------------
  logic [NumStage:1]   vld_q;
  logic [NumStage+1:1] adv;

  always_comb begin
    adv[NumStage+1] = m_axis_tready_i;
    for (int k = NumStage; k >= 1; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end

  assign s_axis_tready_o = adv[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[1]) begin
        vld_q[1] <= s_axis_tvalid_i;
      end
      for (int k = 2; k <= NumStage; k++) begin
        if (adv[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1: unpack, dT = D2 - C5*256, failed-read flag
  // ---------------------------------------------------------------------------
  logic [RawW-1:0]        raw_p, raw_t;
  logic [RawW-1:0]        s1_d1_q;
  logic signed [DtW-1:0]  s1_dt_q, s1_dt_d;
  logic                   s1_zero_q;

  assign raw_p   = s_axis_tdata_i[RawW-1:0];
  assign raw_t   = s_axis_tdata_i[2*RawW-1:RawW];
  assign s1_dt_d = $signed({1'b0, raw_t}) - $signed({1'b0, coef_q[CFG_C5_TREF], 8'h00});

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      s1_d1_q   <= raw_p;
      s1_dt_q   <= s1_dt_d;
      s1_zero_q <= (raw_p == '0) || (raw_t == '0);
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: the three dT products (17s x 25s each)
  // ---------------------------------------------------------------------------
  logic [RawW-1:0]     s2_d1_q;
  logic                s2_zero_q;
  logic signed [41:0]  s2_offp_q, s2_sensp_q, s2_tempp_q;

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      s2_d1_q    <= s1_d1_q;
      s2_zero_q  <= s1_zero_q;
      s2_offp_q  <= $signed({1'b0, coef_q[CFG_C4_TCO]}) * s1_dt_q;
      s2_sensp_q <= $signed({1'b0, coef_q[CFG_C3_TCS]}) * s1_dt_q;
      s2_tempp_q <= s1_dt_q * $signed({1'b0, coef_q[CFG_C6_TEMPSENS]});
    end
  end

  // ---------------------------------------------------------------------------
  // stage 3: truncating shifts, OFF, SENS, TEMP
  // negative values get 2^k-1 added before the shift to round toward zero
  // ---------------------------------------------------------------------------
  logic signed [41:0]       offp_adj, sensp_adj, tempp_adj;
  logic signed [36:0]       s3_off_d, s3_off_q;
  logic signed [35:0]       s3_sens_d, s3_sens_q;
  logic signed [TempW-1:0]  s3_temp_d, s3_temp_q;
  logic [RawW-1:0]          s3_d1_q;
  logic                     s3_zero_q;

  assign offp_adj  = s2_offp_q  + $signed({35'd0, {7{s2_offp_q[41]}}});
  assign sensp_adj = s2_sensp_q + $signed({34'd0, {8{s2_sensp_q[41]}}});
  assign tempp_adj = s2_tempp_q + $signed({19'd0, {23{s2_tempp_q[41]}}});

  assign s3_off_d  = $signed({5'd0, coef_q[CFG_C2_OFF], 16'h0000})
                   + $signed({{2{offp_adj[41]}}, offp_adj[41:7]});
  assign s3_sens_d = $signed({5'd0, coef_q[CFG_C1_SENS], 15'h0000})
                   + $signed({{2{sensp_adj[41]}}, sensp_adj[41:8]});
  assign s3_temp_d = TempBase + $signed(tempp_adj[41:23]);

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      s3_d1_q   <= s2_d1_q;
      s3_zero_q <= s2_zero_q;
      s3_off_q  <= s3_off_d;
      s3_sens_q <= s3_sens_d;
      s3_temp_q <= s3_temp_d;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 4: D1*SENS split into low 17 unsigned and high 19 signed bits of SENS
  // ---------------------------------------------------------------------------
  logic [40:0]              s4_pplo_q;
  logic signed [43:0]       s4_pphi_q;
  logic signed [36:0]       s4_off_q;
  logic signed [TempW-1:0]  s4_temp_q;
  logic                     s4_zero_q;

  always_ff @(posedge clk_i) begin
    if (adv[4]) begin
      s4_pplo_q <= s3_d1_q * s3_sens_q[16:0];
      s4_pphi_q <= $signed({1'b0, s3_d1_q}) * $signed(s3_sens_q[35:17]);
      s4_off_q  <= s3_off_q;
      s4_temp_q <= s3_temp_q;
      s4_zero_q <= s3_zero_q;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 5: sum partial products, truncating divide by 2^21
  // ---------------------------------------------------------------------------
  logic signed [60:0]       prod, prod_adj;
  logic signed [39:0]       s5_q1_q;
  logic signed [36:0]       s5_off_q;
  logic signed [TempW-1:0]  s5_temp_q;
  logic                     s5_zero_q;

  assign prod     = $signed({s4_pphi_q, 17'd0}) + $signed({20'd0, s4_pplo_q});
  assign prod_adj = prod + $signed({40'd0, {21{prod[60]}}});

  always_ff @(posedge clk_i) begin
    if (adv[5]) begin
      s5_q1_q   <= prod_adj[60:21];
      s5_off_q  <= s4_off_q;
      s5_temp_q <= s4_temp_q;
      s5_zero_q <= s4_zero_q;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 6: subtract OFF, truncating divide by 2^15, failed-read masking
  // ---------------------------------------------------------------------------
  logic signed [40:0]       diff, diff_adj;
  logic [PresW-1:0]         s6_pres_d, s6_pres_q;
  logic [TempW-1:0]         s6_temp_q;
  logic                     s6_ok_q;

  assign diff      = $signed({s5_q1_q[39], s5_q1_q}) - $signed({{4{s5_off_q[36]}}, s5_off_q});
  assign diff_adj  = diff + $signed({26'd0, {15{diff[40]}}});
  assign s6_pres_d = {{6{diff_adj[40]}}, diff_adj[40:15]};

  always_ff @(posedge clk_i) begin
    if (adv[6]) begin
      s6_pres_q <= s5_zero_q ? '0 : s6_pres_d;
      s6_temp_q <= s5_zero_q ? '0 : s5_temp_q;
      s6_ok_q   <= !s5_zero_q;
    end
  end

  assign m_axis_tvalid_o = vld_q[NumStage];
  assign m_axis_tdata_o  = {{(OutDataW-PresW-TempW){1'b0}}, s6_temp_q, s6_pres_q};
  assign m_axis_tuser_o  = s6_ok_q;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  logic out_ok, out_fail, temp_in_range, in_zero_xfer;

  assign out_ok        = m_axis_tvalid_o && m_axis_tuser_o;
  assign out_fail      = m_axis_tvalid_o && !m_axis_tuser_o;
  assign temp_in_range = ($signed(s6_temp_q) >= TempMin) && ($signed(s6_temp_q) <= TempMax);
  // accepted transaction with a zero pressure reading
  assign in_zero_xfer  = s_axis_tvalid_i && s_axis_tready_o && (raw_p == '0);

  `BFOC_ASSERT_NOW(a_fail_zero, out_fail, m_axis_tdata_o == '0, "failed read not zeroed")
  `BFOC_ASSERT_NOW(a_stall_full, !s_axis_tready_o, (&vld_q) && !m_axis_tready_i, "early stall")
  `BFOC_ASSERT_NOW(a_temp_range, out_ok, temp_in_range, "temperature out of range")
  `BFOC_ASSERT_NEXT(a_zero_flag, in_zero_xfer, vld_q[1] && s1_zero_q, "zero read not flagged")

endmodule

/* sim/barometer_first_order_compensation_top_tb.sv */
// self-checking testbench for barometer_first_order_compensation_top
// drives reading pairs, predicts compensated pressure/temperature per transaction
// depends on bfoc_pkg and the block's rtl
`timescale 1ns / 1ps

module barometer_first_order_compensation_top_tb;
  import bfoc_pkg::*;

  localparam int unsigned ClkHalf     = 5;
  localparam int unsigned ResetCycles = 6;
  localparam int unsigned IdlePct     = 6;
  localparam int unsigned RandPhases  = 10;
  localparam int unsigned PhaseItems  = 125;
  localparam int unsigned DrainCycles = 20;

  // indexes past the last calibration word, writes there must be dropped
  localparam logic [CfgIdxW-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_HI = 3'd7;

  // scale factors of the first-order compensation
  localparam longint OffScale   = 65536;
  localparam longint OffTcDiv   = 128;
  localparam longint SensScale  = 32768;
  localparam longint SensTcDiv  = 256;
  localparam longint PresDiv    = 2097152;
  localparam longint PresOutDiv = 32768;
  localparam longint TempDiv    = 8388608;
  localparam longint TrefScale  = 256;

  localparam logic [RawW-1:0]  RawMax  = '1;
  localparam logic [CoefW-1:0] CoefMax = '1;

  typedef struct packed {
    logic [PresW-1:0]        pressure;
    logic signed [TempW-1:0] temperature;
    logic                    valid;
  } baro_result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [InDataW-1:0]  s_axis_tdata_i = '0;   // [23:0] raw_pressure, [47:24] raw_temperature
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata_o;        // [31:0] pressure, [50:32] temperature
  logic                m_axis_tuser_o;        // [0] readings_valid
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CoefW-1:0]    cfg_data_i = '0;

  logic [CoefW-1:0]   coef_shadow [NumCoef];
  logic [InDataW-1:0] pending_readings [$];
  baro_result_t       expected_results [$];
  baro_result_t       result_head;
  int unsigned        error_count = 0;
  bit                 no_idle = 1'b0;

  barometer_first_order_compensation_top u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i)
  );

  always #(ClkHalf) clk_i = ~clk_i;

  // compensated pressure and temperature for one reading pair, c-style truncating divides
  function automatic baro_result_t compensate_reading(logic [RawW-1:0] d1,
                                                      logic [RawW-1:0] d2);
    longint dt, off, sens, pres, temp_c;
    baro_result_t r;
    r = '0;
    if (d1 == '0 || d2 == '0) return r;
    dt   = longint'({40'd0, d2}) - longint'({48'd0, coef_shadow[CFG_C5_TREF]}) * TrefScale;
    off  = longint'({48'd0, coef_shadow[CFG_C2_OFF]}) * OffScale
         + (longint'({48'd0, coef_shadow[CFG_C4_TCO]}) * dt) / OffTcDiv;
    sens = longint'({48'd0, coef_shadow[CFG_C1_SENS]}) * SensScale
         + (longint'({48'd0, coef_shadow[CFG_C3_TCS]}) * dt) / SensTcDiv;
    pres = ((longint'({40'd0, d1}) * sens) / PresDiv - off) / PresOutDiv;
    temp_c = longint'(TempBase)
           + (dt * longint'({48'd0, coef_shadow[CFG_C6_TEMPSENS]})) / TempDiv;
    r.pressure    = pres[PresW-1:0];
    r.temperature = temp_c[TempW-1:0];
    r.valid       = 1'b1;
    return r;
  endfunction

  task automatic note_mismatch(string what, longint unsigned got, longint unsigned want);
    error_count++;
    $display("[%0t] mismatch %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
  endtask

  function automatic logic [InDataW-1:0] pack_reading(logic [RawW-1:0] d1,
                                                      logic [RawW-1:0] d2);
    return {d2, d1};
  endfunction

  // mostly valid pairs, temperature often near the reference point, a few failed reads
  function automatic logic [InDataW-1:0] random_reading();
    logic [RawW-1:0] d1, d2;
    int unsigned sel;
    sel = $urandom_range(99);
    d1  = RawW'($urandom_range(RawMax, 1));
    if (sel < 35)
      d2 = RawW'({coef_shadow[CFG_C5_TREF], 8'd0} + $urandom_range(8191) - 4096);
    else
      d2 = RawW'($urandom_range(RawMax, 1));
    if (d2 == '0) d2 = 24'd1;
    if (sel >= 94 && sel < 97) d1 = '0;
    else if (sel >= 97 && sel < 99) d2 = '0;
    else if (sel == 99) begin
      d1 = '0;
      d2 = '0;
    end
    return pack_reading(d1, d2);
  endfunction

  // input side: hold an item until its transaction, then fetch the next or idle
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= '0;
    end else if (!s_axis_tvalid_i || s_axis_tready_o) begin
      if (s_axis_tvalid_i)
        expected_results.push_back(compensate_reading(s_axis_tdata_i[RawW-1:0],
                                                      s_axis_tdata_i[2*RawW-1:RawW]));
      if (pending_readings.size() > 0 && (no_idle || $urandom_range(99) >= IdlePct)) begin
        s_axis_tvalid_i <= 1'b1;
        s_axis_tdata_i  <= pending_readings.pop_front();
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // result side: check each transaction against the oldest prediction, random stalls
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (expected_results.size() == 0) begin
          note_mismatch("unexpected result", m_axis_tdata_o, 0);
        end else begin
          result_head = expected_results.pop_front();
          if (m_axis_tdata_o[PresW-1:0] !== result_head.pressure)
            note_mismatch("pressure_hundredths", m_axis_tdata_o[PresW-1:0],
                          result_head.pressure);
          if (m_axis_tdata_o[PresW +: TempW] !== result_head.temperature)
            note_mismatch("temperature_hundredths", m_axis_tdata_o[PresW +: TempW],
                          result_head.temperature);
          if (m_axis_tuser_o !== result_head.valid)
            note_mismatch("readings_valid", m_axis_tuser_o, result_head.valid);
          if (m_axis_tdata_o[OutDataW-1:PresW+TempW] !== '0)
            note_mismatch("tdata padding", m_axis_tdata_o[OutDataW-1:PresW+TempW], 0);
        end
      end
      m_axis_tready_i <= no_idle || ($urandom_range(99) >= IdlePct);
    end
  end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CoefW-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    if (idx < NumCoef) coef_shadow[idx] = data;
  endtask

  // all six words, plus dropped writes to both indexes past the table
  task automatic program_coefs(logic [CoefW-1:0] c1, logic [CoefW-1:0] c2,
                               logic [CoefW-1:0] c3, logic [CoefW-1:0] c4,
                               logic [CoefW-1:0] c5, logic [CoefW-1:0] c6);
    write_reg(CFG_SPARE_LO, CoefW'($urandom));
    write_reg(CFG_C1_SENS, c1);
    write_reg(CFG_C2_OFF, c2);
    write_reg(CFG_C3_TCS, c3);
    write_reg(CFG_C4_TCO, c4);
    write_reg(CFG_C5_TREF, c5);
    write_reg(CFG_C6_TEMPSENS, c6);
    write_reg(CFG_SPARE_HI, CoefW'($urandom));
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // idle means nothing queued, nothing in flight and every result back
  task automatic wait_drained();
    while (pending_readings.size() > 0 || s_axis_tvalid_i || expected_results.size() > 0)
      @(posedge clk_i);
  endtask

  initial begin
    logic [RawW-1:0] tref_raw;
    for (int i = 0; i < NumCoef; i++) coef_shadow[i] = '0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    // calibration words still at reset: sensitivity and offset are zero
    pending_readings.push_back(pack_reading(RawMax, RawMax));
    pending_readings.push_back(pack_reading(24'd1, 24'd1));
    pending_readings.push_back(pack_reading(24'd9085466, 24'd8569150));
    wait_drained();

    // typical factory words, failed reads and the reference-temperature crossing
    program_coefs(16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312);
    tref_raw = {coef_shadow[CFG_C5_TREF], 8'd0};
    pending_readings.push_back(pack_reading(24'd9085466, 24'd8569150));
    pending_readings.push_back(pack_reading('0, 24'd8569150));
    pending_readings.push_back(pack_reading(24'd9085466, '0));
    pending_readings.push_back(pack_reading('0, '0));
    pending_readings.push_back(pack_reading(24'd9085466, tref_raw));
    pending_readings.push_back(pack_reading(24'd9085466, tref_raw - 24'd1));
    pending_readings.push_back(pack_reading(24'd9085466, tref_raw + 24'd1));
    pending_readings.push_back(pack_reading(24'd9085466, tref_raw - 24'd255));
    pending_readings.push_back(pack_reading(RawMax, RawMax));
    pending_readings.push_back(pack_reading(24'd1, 24'd1));
    pending_readings.push_back(pack_reading(RawMax, 24'd1));
    pending_readings.push_back(pack_reading(24'd1, RawMax));
    pending_readings.push_back(pack_reading(24'hAAAAAA, 24'h555555));
    pending_readings.push_back(pack_reading(24'h555555, 24'hAAAAAA));
    wait_drained();

    // largest words: widest products
    program_coefs(CoefMax, CoefMax, CoefMax, CoefMax, CoefMax, CoefMax);
    pending_readings.push_back(pack_reading(RawMax, RawMax));
    pending_readings.push_back(pack_reading(RawMax, 24'd1));
    pending_readings.push_back(pack_reading(24'd1, 24'd1));
    pending_readings.push_back(pack_reading(24'd1, RawMax));
    pending_readings.push_back(pack_reading(24'h800000, 24'h7FFFFF));
    pending_readings.push_back(pack_reading(RawMax, 24'hFFFF00));
    wait_drained();

    // random phases, each under its own calibration set
    for (int ph = 0; ph < RandPhases; ph++) begin
      if (ph == 0)
        program_coefs('0, '0, '0, '0, '0, '0);
      else if (ph == 1)
        program_coefs(CoefMax, '0, CoefMax, '0, CoefMax, CoefMax);
      else if (ph == 2)
        program_coefs('0, CoefMax, '0, CoefMax, '0, '0);
      else
        program_coefs(CoefW'($urandom), CoefW'($urandom), CoefW'($urandom),
                      CoefW'($urandom), CoefW'($urandom), CoefW'($urandom));
      // one phase runs back to back with no gaps on either side
      no_idle = (ph == 4);
      for (int n = 0; n < PhaseItems; n++) pending_readings.push_back(random_reading());
      wait_drained();
      no_idle = 1'b0;
    end

    repeat (DrainCycles) @(posedge clk_i);
    if (expected_results.size() > 0) note_mismatch("results never returned",
                                                   expected_results.size(), 0);
    if (error_count == 0) begin
      $display("** barometer_first_order_compensation_top: PASSED **");
    end else begin
      $display("** barometer_first_order_compensation_top: FAILED **");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("** barometer_first_order_compensation_top: FAILED **");
    $finish;
  end

endmodule
